// ----- sv/fifo_with_indexed_peek_remove_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the indexed FIFO.
// Every check is clocked by clk; the first form is masked during reset.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_INDEXED_PEEK_REMOVE_TOP_DEFINES_SVH
`define FIFO_WITH_INDEXED_PEEK_REMOVE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that is ignored while reset is asserted.
`define FIPR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
// Check that also holds at edges during reset.
`define FIPR_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FIPR_ASSERT(label, prop, msg)
`define FIPR_ASSERT_RST(label, prop, msg)
`endif

`endif

// ----- sv/fipr_pkg.sv -----
// ----------------------------------------------------------------------------
// fipr_pkg
// Types and constants shared by the indexed FIFO cells and top level.
// ----------------------------------------------------------------------------
package fipr_pkg;

	// Storage geometry.
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	// Fixed port widths.
	localparam int DIN_W   = 32;
	localparam int DOUT_W  = 32;
	localparam int IDX_W   = 4;
	localparam int COUNT_W = 5;

	// Derived widths.
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// Command codes.
	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_PEEK   = 2'd3
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	// Controls broadcast from the top level to every cell.
	typedef struct packed {
		logic  take;     // drop the entry at pos and close the gap
		logic  push;     // write the new word at wr_slot
		slot_t pos;      // slot being dropped
		slot_t wr_slot;  // first free slot
	} cell_ctl_t;

endpackage

// ----- sv/fipr_cell.sv -----
// ----------------------------------------------------------------------------
// fipr_cell
// One storage cell of the shifting queue. It keeps its word, takes the word
// of its newer neighbor when the gap closes, or loads a pushed word.
// ----------------------------------------------------------------------------
module fipr_cell (
	input  logic               clk,
	input  fipr_pkg::slot_t    slot,
	input  fipr_pkg::cell_ctl_t ctl,
	input  fipr_pkg::word_t    nxt_data,
	input  fipr_pkg::word_t    push_data,
	output fipr_pkg::word_t    data
);
	import fipr_pkg::*;

	word_t data_q;

	// Cells at and above the dropped slot move down by one.
	always_ff @(posedge clk) begin
		if (ctl.take && (slot >= ctl.pos)) begin
			data_q <= nxt_data;
		end else if (ctl.push && (slot == ctl.wr_slot)) begin
			data_q <= push_data;
		end
	end

	assign data = data_q;

endmodule

// ----- sv/fifo_with_indexed_peek_remove_top.sv -----
// ----------------------------------------------------------------------------
// fifo_with_indexed_peek_remove_top
// Bounded FIFO with push, pop, and peek or removal by index from the newest
// entry, built as a row of shifting storage cells.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------
//  in      | in_valid / in_stall     | cmd, data_in, index
//  out     | out_valid / out_stall   | data_out, found, status, count
//
// For each request the cells shift, load or are read in the cycle of
// acceptance and the result lands in the output register.
// A new request is taken every cycle while the output is not stalled;
// in_stall is high only while a held result is stalled.
// Reset clears the entry count and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
`include "fifo_with_indexed_peek_remove_top_defines.svh"

module fifo_with_indexed_peek_remove_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    cmd,
	input  logic [fipr_pkg::DIN_W-1:0]    data_in,
	input  logic [fipr_pkg::IDX_W-1:0]    index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fipr_pkg::DOUT_W-1:0]   data_out,
	output logic                          found,
	output logic [1:0]                    status,
	output logic [fipr_pkg::COUNT_W-1:0]  count
);
	import fipr_pkg::*;

	logic                 acc;
	cnt_t                 cnt_q;
	cnt_t                 cnt_nxt;
	logic [CMP_W-1:0]     idx_w;
	logic [CMP_W-1:0]     cnt_w;
	logic [CMP_W-1:0]     pos_w;
	logic                 in_range;
	logic                 push_ok;
	logic                 pop_ok;
	logic                 rem_ok;
	logic                 hit;
	slot_t                rd_slot;
	status_t              st;
	cell_ctl_t            ctl;
	word_t                push_word;
	word_t                cell_data [DEPTH];
	word_t                nxt_data  [DEPTH];
	logic                 out_valid_q;
	logic [DOUT_W-1:0]    dout_q;
	logic                 found_q;
	status_t              status_q;
	cnt_t                 count_q;

	// Handshake: hold off new requests while a result is stalled.
	assign in_stall = out_valid_q && out_stall;
	assign acc      = in_valid && !in_stall;

	// Index decode: slot = count - 1 - index, oldest entry in slot 0.
	assign idx_w    = CMP_W'(index);
	assign cnt_w    = CMP_W'(cnt_q);
	assign in_range = idx_w < cnt_w;
	assign pos_w    = cnt_w - CMP_W'(1) - idx_w;

	always_comb begin
		push_ok = 1'b0;
		pop_ok  = 1'b0;
		rem_ok  = 1'b0;
		hit     = 1'b0;
		rd_slot = pos_w[SLOT_W-1:0];
		st      = ST_OK;
		case (cmd_t'(cmd))
			CMD_PUSH: begin
				if (cnt_q == CNT_W'(DEPTH)) begin
					st = ST_FULL;
				end else begin
					push_ok = acc;
				end
			end
			CMD_POP: begin
				rd_slot = '0;
				if (cnt_q == '0) begin
					st = ST_MISS;
				end else begin
					pop_ok = acc;
					hit    = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (!in_range) begin
					st = ST_MISS;
				end else begin
					rem_ok = acc;
					hit    = 1'b1;
				end
			end
			default: begin
				if (!in_range) begin
					st = ST_MISS;
				end else begin
					hit = 1'b1;
				end
			end
		endcase
	end

	// Controls broadcast to the cell row.
	assign ctl.take    = pop_ok || rem_ok;
	assign ctl.push    = push_ok;
	assign ctl.pos     = rd_slot;
	assign ctl.wr_slot = cnt_q[SLOT_W-1:0];
	assign push_word   = word_t'(data_in);

	// Row of cells; each cell hands its word to the older neighbor.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_last
			assign nxt_data[i] = '0;
		end else begin : g_mid
			assign nxt_data[i] = cell_data[i+1];
		end
		fipr_cell u_cell (
			.clk       (clk),
			.slot      (SLOT_W'(i)),
			.ctl       (ctl),
			.nxt_data  (nxt_data[i]),
			.push_data (push_word),
			.data      (cell_data[i])
		);
	end

	// Entry count after the request.
	always_comb begin
		cnt_nxt = cnt_q;
		if (push_ok) begin
			cnt_nxt = cnt_q + CNT_W'(1);
		end else if (ctl.take) begin
			cnt_nxt = cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			dout_q   <= hit ? DOUT_W'(cell_data[rd_slot]) : '0;
			found_q  <= hit;
			status_q <= st;
			count_q  <= cnt_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = dout_q;
	assign found     = found_q;
	assign status    = status_q;
	assign count     = COUNT_W'(count_q);

	// Checks on the count, the result codes and the input stall.
	`FIPR_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "entry count above depth")
	`FIPR_ASSERT(a_cnt_hold, !acc |=> $stable(cnt_q), "count moved without a request")
	`FIPR_ASSERT(a_full_push, (acc && cmd == CMD_PUSH && cnt_q == CNT_W'(DEPTH)) |=> (status == ST_FULL && !found && $stable(cnt_q)), "push into full queue not rejected")
	`FIPR_ASSERT(a_found_ok, (out_valid && found) |-> (status == ST_OK), "found with error status")
	`FIPR_ASSERT_RST(a_stall_held, in_stall |-> out_valid, "input stalled with no held result")

endmodule

// ----- tb/tb_fifo_with_indexed_peek_remove_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_with_indexed_peek_remove_top
// Self-checking bench for the bounded FIFO with indexed peek and removal.
// A queue-based predictor mirrors the entry store. Every accepted request
// yields one expected result, and each delivered result is checked field by
// field in order. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_fifo_with_indexed_peek_remove_top;
	import fipr_pkg::*;

	localparam int RANDOM_REQUESTS = 1325;
	localparam int CYCLE_LIMIT     = 400000;

	// One pending request for the driver. A drain marker carries no command.
	typedef struct {
		cmd_t            op;
		logic [DIN_W-1:0] word;
		logic [IDX_W-1:0] idx;
		int unsigned     gap;
		bit              drain;
	} request_t;

	// One expected result.
	typedef struct {
		logic [DOUT_W-1:0]  word;
		logic               hit;
		status_t            st;
		logic [COUNT_W-1:0] cnt;
	} result_t;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          cmd = 2'd0;
	logic [DIN_W-1:0]    data_in = '0;
	logic [IDX_W-1:0]    index = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [DOUT_W-1:0]   data_out;
	logic                found;
	logic [1:0]          status;
	logic [COUNT_W-1:0]  count;

	request_t    pending_requests[$];
	result_t     expected_results[$];
	word_t       stored_words[$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_left = 0;
	bit          stall_quiet = 1'b0;
	bit          gaps_on = 1'b1;
	int unsigned level = 0;
	int unsigned accepted_count = 0;
	int unsigned delivered_count = 0;
	int unsigned refused_count = 0;
	int unsigned miss_count = 0;
	int unsigned drain_count = 0;
	result_t     got;
	result_t     want;

	fifo_with_indexed_peek_remove_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.data_in   (data_in),
		.index     (index),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_out  (data_out),
		.found     (found),
		.status    (status),
		.count     (count)
	);

	// Clock generation.
	initial begin
		forever #5 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned idle_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			return 0;
		else if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 20);
	endfunction

	// Apply one command to the mirrored store and return its result.
	function automatic result_t fifo_apply(cmd_t op, logic [DIN_W-1:0] din,
			logic [IDX_W-1:0] idx);
		result_t res;
		int      pos;
		res.word = '0;
		res.hit  = 1'b0;
		res.st   = ST_OK;
		case (op)
			CMD_PUSH: begin
				if (stored_words.size() >= DEPTH) begin
					res.st = ST_FULL;
					refused_count++;
				end else begin
					stored_words.push_back(word_t'(din));
				end
			end
			CMD_POP: begin
				if (stored_words.size() == 0) begin
					res.st = ST_MISS;
				end else begin
					res.word = stored_words.pop_front();
					res.hit  = 1'b1;
				end
			end
			default: begin
				if (idx >= stored_words.size()) begin
					res.st = ST_MISS;
				end else begin
					// Index 0 is the newest entry, which sits at the back.
					pos = stored_words.size() - 1 - idx;
					res.word = stored_words[pos];
					res.hit  = 1'b1;
					if (op == CMD_REMOVE)
						stored_words.delete(pos);
				end
			end
		endcase
		if (res.st == ST_MISS)
			miss_count++;
		if (res.hit)
			delivered_count++;
		res.cnt = COUNT_W'(stored_words.size());
		return res;
	endfunction

	// Queue a request and track the entry count it leaves behind.
	task automatic add_request(cmd_t op, logic [DIN_W-1:0] word, logic [IDX_W-1:0] idx,
			bit drain);
		request_t req;
		req.op    = op;
		req.word  = word;
		req.idx   = idx;
		req.drain = drain;
		req.gap   = gaps_on ? idle_length() : 0;
		pending_requests.push_back(req);
		if (!drain) begin
			if (op == CMD_PUSH && level < DEPTH)
				level++;
			else if (op == CMD_POP && level > 0)
				level--;
			else if (op == CMD_REMOVE && idx < level)
				level--;
		end
	endtask

	task automatic report_mismatch(string field, logic [31:0] exp_val, logic [31:0] act_val);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, field,
				exp_val, act_val);
	endtask

	// Request driver: predicts on acceptance, then presents the next request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(fifo_apply(cmd_t'(cmd), data_in, index));
				accepted_count++;
			end
			if (!(in_valid && in_stall)) begin
				if (pending_requests.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pending_requests[0].drain) begin
					// Hold off until every outstanding result has come back.
					in_valid <= 1'b0;
					if (expected_results.size() == 0) begin
						void'(pending_requests.pop_front());
						drain_count++;
					end
				end else if (pending_requests[0].gap > 0) begin
					in_valid <= 1'b0;
					pending_requests[0].gap = pending_requests[0].gap - 1;
				end else begin
					in_valid <= 1'b1;
					cmd      <= pending_requests[0].op;
					data_in  <= pending_requests[0].word;
					index    <= pending_requests[0].idx;
					void'(pending_requests.pop_front());
				end
			end
		end
	end

	// Result monitor: checks accepted results and drives random stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.word = data_out;
				got.hit  = found;
				got.st   = status_t'(status);
				got.cnt  = count;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, data_out", 32'h0, got.word);
				end else begin
					want = expected_results.pop_front();
					if (got.word !== want.word)
						report_mismatch("data_out", want.word, got.word);
					if (got.hit !== want.hit)
						report_mismatch("found", 32'(want.hit), 32'(got.hit));
					if (got.st !== want.st)
						report_mismatch("status", 32'(want.st), 32'(got.st));
					if (got.cnt !== want.cnt)
						report_mismatch("count", 32'(want.cnt), 32'(got.cnt));
				end
			end
			// At regular points in the cycle count, decide whether stalls are on at all.
			if (cycle_count % 300 == 0)
				stall_quiet = ($urandom_range(0, 3) == 0);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = stall_quiet ? 0 : idle_length();
			end
		end
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
				expected_results.size());
			$display("FAIL fifo_with_indexed_peek_remove_top");
			$finish;
		end
	end

	// Stimulus and end of test.
	initial begin
		mix_t        mix;
		int unsigned mix_left;
		int unsigned pick;
		int unsigned push_pct;
		int unsigned pop_pct;
		int unsigned remove_pct;
		cmd_t        op;
		logic [31:0] word;
		logic [3:0]  idx;

		mix = MIX_EVEN;
		mix_left = 0;

		// Directed: misses on the empty queue.
		add_request(CMD_POP, 32'h0, 4'd0, 1'b0);
		add_request(CMD_PEEK, 32'h0, 4'd0, 1'b0);
		add_request(CMD_REMOVE, 32'h0, 4'd15, 1'b0);
		// A zero word is a real entry; the all-ones word covers the top bits.
		add_request(CMD_PUSH, 32'h0, 4'd0, 1'b0);
		add_request(CMD_PUSH, 32'hFFFF_FFFF, 4'd0, 1'b0);
		add_request(CMD_PEEK, 32'h0, 4'd1, 1'b0);
		add_request(CMD_PEEK, 32'h0, 4'd2, 1'b0);
		// Fill to capacity, then one push too many.
		for (int i = 0; i < DEPTH - 2; i++)
			add_request(CMD_PUSH, $urandom, 4'd0, 1'b0);
		add_request(CMD_PUSH, 32'hA5A5_5A5A, 4'd0, 1'b0);
		// Oldest and newest entries by index.
		add_request(CMD_PEEK, 32'h0, 4'd15, 1'b0);
		add_request(CMD_REMOVE, 32'h0, 4'd15, 1'b0);
		add_request(CMD_REMOVE, 32'h0, 4'd0, 1'b0);

		// Random part in phases that lean toward filling, draining or neither.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (mix_left == 0) begin
				mix = mix_t'($urandom_range(0, 2));
				mix_left = $urandom_range(30, 120);
				gaps_on = ($urandom_range(0, 3) != 0);
			end
			mix_left--;
			case (mix)
				MIX_FILL: begin
					push_pct = 70;
					pop_pct = 10;
					remove_pct = 10;
				end
				MIX_DRAIN: begin
					push_pct = 20;
					pop_pct = 25;
					remove_pct = 30;
				end
				default: begin
					push_pct = 25;
					pop_pct = 25;
					remove_pct = 25;
				end
			endcase
			pick = $urandom_range(0, 99);
			if (pick < push_pct)
				op = CMD_PUSH;
			else if (pick < push_pct + pop_pct)
				op = CMD_POP;
			else if (pick < push_pct + pop_pct + remove_pct)
				op = CMD_REMOVE;
			else
				op = CMD_PEEK;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				word = 32'h0;
			else if (pick < 10)
				word = 32'hFFFF_FFFF;
			else
				word = $urandom;
			// Mostly valid indices, some anywhere in the field.
			if (level > 0 && $urandom_range(0, 5) != 0)
				idx = 4'($urandom_range(0, level - 1));
			else
				idx = 4'($urandom_range(0, 15));
			add_request(op, word, idx, 1'b0);
			if (n == 500 || n == 1000)
				add_request(CMD_PUSH, 32'h0, 4'd0, 1'b1);
		end

		// Reset, released away from the rising edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Ran %0d requests: %0d words returned, %0d full-queue pushes refused,",
			accepted_count, delivered_count, refused_count);
		$display("%0d empty or out-of-range misses, %0d full drains of the result side.",
			miss_count, drain_count);
		if (fail_count == 0) begin
			$display("PASS fifo_with_indexed_peek_remove_top");
		end else begin
			$display("%0d mismatches in total.", fail_count);
			$display("FAIL fifo_with_indexed_peek_remove_top");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/fipr_pkg.sv
sv/fipr_cell.sv
sv/fifo_with_indexed_peek_remove_top.sv
tb/tb_fifo_with_indexed_peek_remove_top.sv
